// ===== hdl/kbm_pkg.sv =====
package kbm_pkg;

  // Limb and operand geometry.
  localparam int LIMB_W    = 27;
  localparam int IN_LIMBS  = 4;
  localparam int OUT_LIMBS = 8;
  localparam int PROD_W    = 2 * LIMB_W;
  localparam int COL_W     = PROD_W + 3;
  localparam int Q_W       = 31;
  localparam int CNT_W     = 4;
  localparam int CARRY_W   = 5;

  // Radix and reciprocal of the radix scaled by 2^58 / 2^26.
  localparam logic [LIMB_W-1:0] LIMB_BASE = 27'd100000000;
  localparam logic [31:0]       RECIP     = 32'd2882303761;

  typedef logic [LIMB_W-1:0] limb_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [Q_W-1:0]    quot_t;

endpackage

// ===== hdl/karatsuba_base1e8_multiplier.sv =====
// Channel   Handshake            Payload
// input     in_valid/in_ready    a_limb0..a_limb3, b_limb0..b_limb3
// output    out_valid/out_ready  p_limb0..p_limb7, used_limbs
//
// One operand pair enters every cycle unless a waiting result stalls the pipeline.
// Stages: products, column sums, two three-stage radix splits, carry ripple,
// limb count. The 31x32 reciprocal multiplies set the stage depth.
// The whole pipeline advances together; it stalls only while a result waits.
// Reset clears the valid bits; data registers are not reset.
module karatsuba_base1e8_multiplier
  import kbm_pkg::*;
#(
  parameter int LIMBS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [26:0] a_limb0,
  input  logic [26:0] a_limb1,
  input  logic [26:0] a_limb2,
  input  logic [26:0] a_limb3,
  input  logic [26:0] b_limb0,
  input  logic [26:0] b_limb1,
  input  logic [26:0] b_limb2,
  input  logic [26:0] b_limb3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [26:0] p_limb0,
  output logic [26:0] p_limb1,
  output logic [26:0] p_limb2,
  output logic [26:0] p_limb3,
  output logic [26:0] p_limb4,
  output logic [26:0] p_limb5,
  output logic [26:0] p_limb6,
  output logic [26:0] p_limb7,
  output logic [3:0]  used_limbs
);

  localparam int DEPTH = 10;

  logic             en;
  logic [DEPTH-1:0] vld;
  limb_t            a [IN_LIMBS];
  limb_t            b [IN_LIMBS];
  col_t             col [OUT_LIMBS];
  col_t             s [OUT_LIMBS];
  limb_t            r1 [OUT_LIMBS];
  quot_t            q1 [OUT_LIMBS];
  limb_t            r2 [OUT_LIMBS];
  quot_t            q2 [OUT_LIMBS];
  limb_t            p [OUT_LIMBS];

  // The pipeline moves whenever the output register is free or drained.
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  assign a = '{a_limb0, a_limb1, a_limb2, a_limb3};
  assign b = '{b_limb0, b_limb1, b_limb2, b_limb3};

  kbm_mulcols #(.LIMBS(LIMBS)) u_mulcols (
    .clk (clk),
    .en  (en),
    .a   (a),
    .b   (b),
    .col (col)
  );

  // Two rounds of radix splitting shrink each column's carry.
  genvar k;
  generate
    for (k = 0; k < OUT_LIMBS; k++) begin : g_lane
      kbm_split u_split1 (
        .clk (clk),
        .en  (en),
        .x   (col[k]),
        .r   (r1[k]),
        .q   (q1[k])
      );

      if (k == 0) begin : g_first
        assign s[k] = COL_W'(r1[k]);
      end else begin : g_rest
        assign s[k] = COL_W'(r1[k]) + COL_W'(q1[k-1]);
      end

      kbm_split u_split2 (
        .clk (clk),
        .en  (en),
        .x   (s[k]),
        .r   (r2[k]),
        .q   (q2[k])
      );
    end
  endgenerate

  kbm_norm u_norm (
    .clk  (clk),
    .en   (en),
    .r    (r2),
    .q    (q2),
    .p    (p),
    .used (used_limbs)
  );

  assign p_limb0 = p[0];
  assign p_limb1 = p[1];
  assign p_limb2 = p[2];
  assign p_limb3 = p[3];
  assign p_limb4 = p[4];
  assign p_limb5 = p[5];
  assign p_limb6 = p[6];
  assign p_limb7 = p[7];

endmodule

// ===== hdl/kbm_mulcols.sv =====
module kbm_mulcols
  import kbm_pkg::*;
#(
  parameter int LIMBS = 4
) (
  input  logic  clk,
  input  logic  en,
  input  limb_t a [IN_LIMBS],
  input  limb_t b [IN_LIMBS],
  output col_t  col [OUT_LIMBS]
);

  logic [PROD_W-1:0] prod [IN_LIMBS][IN_LIMBS];
  col_t              col_next [OUT_LIMBS];
  limb_t             a_m [IN_LIMBS];
  limb_t             b_m [IN_LIMBS];

  // Limbs beyond the configured operand length count as zero.
  always_comb begin
    for (int i = 0; i < IN_LIMBS; i++) begin
      a_m[i] = (i < LIMBS) ? a[i] : '0;
      b_m[i] = (i < LIMBS) ? b[i] : '0;
    end
  end

  // Stage one: all limb-pair products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < IN_LIMBS; i++) begin
        for (int j = 0; j < IN_LIMBS; j++) begin
          prod[i][j] <= PROD_W'(a_m[i]) * PROD_W'(b_m[j]);
        end
      end
    end
  end

  // Stage two: sum the products that share a column.
  always_comb begin
    for (int k = 0; k < OUT_LIMBS; k++) begin
      col_next[k] = '0;
    end
    for (int i = 0; i < IN_LIMBS; i++) begin
      for (int j = 0; j < IN_LIMBS; j++) begin
        col_next[i+j] = col_next[i+j] + COL_W'(prod[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col <= col_next;
    end
  end

endmodule

// ===== hdl/kbm_split.sv =====
module kbm_split
  import kbm_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  col_t  x,
  output limb_t r,
  output quot_t q
);

  logic [62:0]      prod1;
  quot_t            qe1;
  quot_t            qe2;
  col_t             x1;
  col_t             x2;
  logic [COL_W:0]   m2;
  logic [COL_W:0]   diff;
  logic [29:0]      rem;

  // Estimate the quotient from the top bits; it is low by at most two.
  assign prod1 = 63'(x[COL_W-1:26]) * 63'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      qe1 <= prod1[62:32];
      x1  <= x;
    end
  end

  // Multiply the estimate back by the radix.
  always_ff @(posedge clk) begin
    if (en) begin
      m2  <= (COL_W+1)'(qe1) * (COL_W+1)'(LIMB_BASE);
      qe2 <= qe1;
      x2  <= x1;
    end
  end

  assign diff = {1'b0, x2} - m2;
  assign rem  = diff[29:0];

  // Correct the estimate by up to two.
  always_ff @(posedge clk) begin
    if (en) begin
      priority if (rem >= 30'(2 * 100000000)) begin
        r <= LIMB_W'(rem - 30'(2 * 100000000));
        q <= qe2 + Q_W'(2);
      end else if (rem >= 30'(LIMB_BASE)) begin
        r <= LIMB_W'(rem - 30'(LIMB_BASE));
        q <= qe2 + Q_W'(1);
      end else begin
        r <= LIMB_W'(rem);
        q <= qe2;
      end
    end
  end

endmodule

// ===== hdl/kbm_norm.sv =====
module kbm_norm
  import kbm_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  limb_t      r [OUT_LIMBS],
  input  quot_t      q [OUT_LIMBS],
  output limb_t      p [OUT_LIMBS],
  output logic [CNT_W-1:0] used
);

  limb_t                limb [OUT_LIMBS];
  limb_t                limb_next [OUT_LIMBS];
  logic [CNT_W-1:0]     used_next;
  logic [LIMB_W:0]      u [OUT_LIMBS];
  logic [OUT_LIMBS-1:0] gen;
  logic [OUT_LIMBS-1:0] prop;
  logic [OUT_LIMBS-1:0] c;
  logic                 co;

  // Final carry ripple; each carry is zero or one, the top carry is dropped.
  // Generate and propagate flags keep the carry chain one bit wide.
  always_comb begin
    u[0] = (LIMB_W+1)'(r[0]);
    for (int k = 1; k < OUT_LIMBS; k++) begin
      u[k] = (LIMB_W+1)'(r[k]) + (LIMB_W+1)'(q[k-1][CARRY_W-1:0]);
    end
    for (int k = 0; k < OUT_LIMBS; k++) begin
      gen[k]  = (u[k] >= (LIMB_W+1)'(LIMB_BASE));
      prop[k] = (u[k] == (LIMB_W+1)'(LIMB_BASE) - (LIMB_W+1)'(1));
    end
    c[0] = 1'b0;
    for (int k = 0; k < OUT_LIMBS - 1; k++) begin
      c[k+1] = gen[k] | (prop[k] & c[k]);
    end
    co = 1'b0;
    for (int k = 0; k < OUT_LIMBS; k++) begin
      co = gen[k] | (prop[k] & c[k]);
      if (co) begin
        limb_next[k] = LIMB_W'(u[k] + (LIMB_W+1)'(c[k]) - (LIMB_W+1)'(LIMB_BASE));
      end else begin
        limb_next[k] = LIMB_W'(u[k] + (LIMB_W+1)'(c[k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      limb <= limb_next;
    end
  end

  // Count of significant limbs, at least one.
  always_comb begin
    used_next = CNT_W'(1);
    for (int k = 0; k < OUT_LIMBS; k++) begin
      if (limb[k] != '0) begin
        used_next = CNT_W'(k + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p    <= limb;
      used <= used_next;
    end
  end

endmodule

// ===== hdl/kbm_checker.sv =====
module kbm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [26:0] p_limb0,
  input logic [26:0] p_limb7,
  input logic [3:0]  used_limbs
);

  // A stalled result stays valid and holds its lowest limb and its limb count.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(p_limb0) && $stable(used_limbs))
    else $error("stalled result changed");

  // Input is refused exactly while a result is held back.
  assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready disagrees with output stall");

  // The limb count lies in range and agrees with the top limb.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> used_limbs >= 4'd1 && used_limbs <= 4'd8 &&
      ((used_limbs == 4'd8) == (p_limb7 != 27'd0)))
    else $error("limb count inconsistent");

  // The lowest and highest result limbs are normalized.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> p_limb0 < 27'd100000000 && p_limb7 < 27'd100000000)
    else $error("result limb not normalized");

endmodule

bind karatsuba_base1e8_multiplier kbm_checker u_kbm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .p_limb0    (p_limb0),
  .p_limb7    (p_limb7),
  .used_limbs (used_limbs)
);
